### sv/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and controller/datapath interface types of the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int ReqW   = 3;
  localparam int ValW   = 32;
  localparam int PosW   = 7;
  localparam int StatW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_READ_ALL  = 3'd6,
    REQ_NONE      = 3'd7
  } req_t;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic read_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic rd_go;
    logic read_last;
  } dp_sts_t;

endpackage

### sv/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: accepts an item, runs it, then steps any read-out.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output ple_pkg::dp_cmd_t cmd,
  input  ple_pkg::dp_sts_t sts
);
  import ple_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   accept;

  assign in_stall = in_stall_r;
  assign accept   = in_valid && !in_stall_r;

  always_comb begin
    cmd.latch     = accept;
    cmd.exec      = (state_r == S_EXEC) && sts.out_free;
    cmd.read_step = (state_r == S_READ) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_EXEC;
            in_stall_r <= 1'b1;
          end
        end
        S_EXEC: begin
          if (sts.out_free) begin
            if (sts.rd_go) begin
              state_r <= S_READ;
            end else begin
              state_r    <= S_IDLE;
              in_stall_r <= 1'b0;
            end
          end
        end
        S_READ: begin
          if (sts.out_free && sts.read_last) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

### sv/ple_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_dpath
// Shifting cell chain, element count and result register of the list engine.
// ----------------------------------------------------------------------------
module ple_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ple_pkg::dp_cmd_t            cmd,
  output ple_pkg::dp_sts_t            sts,
  input  logic [ple_pkg::ReqW-1:0]    in_req_type,
  input  logic signed [ple_pkg::ValW-1:0] in_value,
  input  logic [ple_pkg::PosW-1:0]    in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ple_pkg::StatW-1:0]   out_status,
  output logic signed [ple_pkg::ValW-1:0] out_element,
  output logic [ple_pkg::PosW-1:0]    out_element_index,
  output logic [ple_pkg::PosW-1:0]    out_item_count,
  output logic                        out_last
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PosW-1:0] CapP = PosW'(CAPACITY);

  logic signed [ValW-1:0] cell_r   [CAPACITY];
  logic signed [ValW-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [ReqW-1:0]        req_r;
  logic signed [ValW-1:0] val_r;
  logic [PosW-1:0]        pos_r;
  logic [PosW-1:0]        rd_idx_r;

  logic                   out_valid_r;
  logic [StatW-1:0]       out_status_r;
  logic signed [ValW-1:0] out_element_r;
  logic [PosW-1:0]        out_index_r;
  logic [PosW-1:0]        out_count_r;
  logic                   out_last_r;

  logic [PosW-1:0] cnt7, rd_idx_inc, k;
  logic            do_ins, do_del, load;
  status_t         st;

  assign cnt7       = PosW'(cnt_r);
  assign rd_idx_inc = rd_idx_r + 1'b1;

  always_comb begin
    st     = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    k      = '0;
    case (req_t'(req_r))
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
        if (cnt7 == CapP) begin
          st = ST_FULL;
        end else if (req_t'(req_r) == REQ_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (req_t'(req_r) == REQ_INS_BACK) begin
          do_ins = 1'b1;
          k      = cnt7;
        end else if (pos_r == '0 || pos_r > cnt7 + 1'b1) begin
          st = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          k      = pos_r - 1'b1;
        end
      end
      REQ_DEL_FRONT: begin
        if (cnt7 == '0) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      REQ_DEL_BACK: begin
        if (cnt7 == '0) begin
          st = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          k      = cnt7 - 1'b1;
        end
      end
      REQ_DEL_POS: begin
        if (pos_r == '0 || pos_r > cnt7) begin
          st = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          k      = pos_r - 1'b1;
        end
      end
      REQ_READ_ALL: begin
        if (cnt7 == '0) st = ST_EMPTY;
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    sts.out_free  = !out_valid_r || !out_stall;
    sts.rd_go     = (req_t'(req_r) == REQ_READ_ALL) && (cnt7 != '0);
    sts.read_last = (rd_idx_inc == cnt7);
  end

  // cell chain: insert shifts up, delete shifts down, read-out rotates
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.exec && do_ins) begin
      cnt_nxt = cnt_r + 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (PosW'(i) == k) begin
          cell_nxt[i] = val_r;
        end else if (i > 0 && PosW'(i) > k && PosW'(i) <= cnt7) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
      end
    end else if (cmd.exec && do_del) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (i < CAPACITY - 1 && PosW'(i) >= k && PosW'(i) + 1'b1 < cnt7) begin
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end else if (cmd.read_step) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (PosW'(i) + 1'b1 == cnt7) begin
          cell_nxt[i] = cell_r[0];
        end else if (i < CAPACITY - 1 && PosW'(i) + 1'b1 < cnt7) begin
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign load = (cmd.exec && !sts.rd_go) || cmd.read_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.latch) begin
      req_r <= in_req_type;
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.exec) begin
      rd_idx_r <= '0;
    end else if (cmd.read_step) begin
      rd_idx_r <= rd_idx_inc;
    end
    if (cmd.exec && !sts.rd_go) begin
      out_status_r  <= st;
      out_element_r <= '0;
      out_index_r   <= '0;
      out_count_r   <= PosW'(cnt_nxt);
      out_last_r    <= 1'b1;
    end else if (cmd.read_step) begin
      out_status_r  <= ST_OK;
      out_element_r <= cell_r[0];
      out_index_r   <= rd_idx_inc;
      out_count_r   <= cnt7;
      out_last_r    <= sts.read_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element       = out_element_r;
  assign out_element_index = out_index_r;
  assign out_item_count    = out_count_r;
  assign out_last          = out_last_r;

endmodule

### sv/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed values with positional insert and delete.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_req_type, in_value, in_position
//  out     | output    | out_valid, out_stall, out_status, out_element,
//          |           | out_element_index, out_item_count, out_last
//
//  Insert, delete and other single-result requests are accepted, then update
//  the cell chain and load the result register. A read-out is accepted, then
//  rotates the chain once per element emitted. Reset clears the count and the
//  result valid; cells hold garbage until written. A stalled result holds the
//  engine in its current step.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ple_pkg::ReqW-1:0]        in_req_type,
  input  logic signed [ple_pkg::ValW-1:0] in_value,
  input  logic [ple_pkg::PosW-1:0]        in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ple_pkg::StatW-1:0]       out_status,
  output logic signed [ple_pkg::ValW-1:0] out_element,
  output logic [ple_pkg::PosW-1:0]        out_element_index,
  output logic [ple_pkg::PosW-1:0]        out_item_count,
  output logic                            out_last
);
  import ple_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ple_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_item_count    (out_item_count),
    .out_last          (out_last)
  );

endmodule

### tb/ple_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Watches both channels of the list engine and keeps its own copy of the
// list. Each accepted request is played against that copy to build the
// results it should give. Each accepted result is compared field by field
// with the oldest one still waiting. The failure count, the number of
// results still awaited and the current list length go to the top.
// ----------------------------------------------------------------------------
module ple_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ple_pkg::ReqW-1:0]        in_req_type,
  input  logic signed [ple_pkg::ValW-1:0] in_value,
  input  logic [ple_pkg::PosW-1:0]        in_position,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ple_pkg::StatW-1:0]       out_status,
  input  logic signed [ple_pkg::ValW-1:0] out_element,
  input  logic [ple_pkg::PosW-1:0]        out_element_index,
  input  logic [ple_pkg::PosW-1:0]        out_item_count,
  input  logic                            out_last,
  output int                              fail_count,
  output int                              pending,
  output int                              list_len
);
  import ple_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_t                status;
    logic signed [ValW-1:0] element;
    logic [PosW-1:0]        index;
    logic [PosW-1:0]        count;
    logic                   last;
  } list_result_t;

  logic signed [ValW-1:0] list_vals [CAPACITY];
  list_result_t           expected_results [$];
  list_result_t           want;

  function automatic void push_result(status_t st, logic signed [ValW-1:0] elem, int idx,
                                      logic is_last);
    list_result_t r;
    r.status  = st;
    r.element = elem;
    r.index   = PosW'(idx);
    r.count   = PosW'(list_len);
    r.last    = is_last;
    expected_results.push_back(r);
  endfunction

  function automatic void insert_value(int at, logic signed [ValW-1:0] v);
    for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
    list_vals[at] = v;
    list_len++;
  endfunction

  function automatic void remove_value(int at);
    for (int i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
  endfunction

  function automatic void predict_request(req_t req, logic signed [ValW-1:0] v, int pos);
    status_t st;
    st = ST_OK;
    case (req)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else if (req == REQ_INS_FRONT) insert_value(0, v);
        else if (req == REQ_INS_BACK) insert_value(list_len, v);
        else if (pos < 1 || pos > list_len + 1) st = ST_BADPOS;
        else insert_value(pos - 1, v);
      end
      REQ_DEL_FRONT: begin
        if (list_len == 0) st = ST_EMPTY;
        else remove_value(0);
      end
      REQ_DEL_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else remove_value(list_len - 1);
      end
      REQ_DEL_POS: begin
        if (pos < 1 || pos > list_len) st = ST_BADPOS;
        else remove_value(pos - 1);
      end
      REQ_READ_ALL: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++)
            push_result(ST_OK, list_vals[i], i + 1, (i + 1 == list_len));
          return;
        end
      end
      default: ;
    endcase
    push_result(st, '0, 0, 1'b1);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      list_len   = 0;
      pending    = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result: status %0d element %0d index %0d count %0d last %0d",
                     $time, out_status, out_element, out_element_index, out_item_count,
                     out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_element !== want.element ||
              out_element_index !== want.index || out_item_count !== want.count ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected: status %0d element %0d index %0d count %0d last %0d",
                       want.status, want.element, want.index, want.count, want.last);
              $display("  actual:   status %0d element %0d index %0d count %0d last %0d",
                       out_status, out_element, out_element_index, out_item_count, out_last);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        predict_request(req_t'(in_req_type), in_value, int'(in_position));
      pending = expected_results.size();
    end
  end

endmodule

### tb/tb_positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Drives requests into the list engine: a directed pass over empty, full and
// bad-position cases, then random grow, shrink, mixed and noise sequences
// with random idling on both channels, one long result hold-off and several
// drain pauses. A checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int NUM_ITEMS   = 150;
  localparam int LONG_HOLD   = 300;
  localparam int END_SETTLE  = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [ReqW-1:0]        in_req_type;
  logic signed [ValW-1:0] in_value;
  logic [PosW-1:0]        in_position;
  logic                   out_valid;
  logic                   out_stall;
  logic [StatW-1:0]       out_status;
  logic signed [ValW-1:0] out_element;
  logic [PosW-1:0]        out_element_index;
  logic [PosW-1:0]        out_item_count;
  logic                   out_last;

  int fail_count;
  int pending;
  int list_len;
  int issued;
  int cycle_count;
  bit gaps_on;
  bit long_hold_pending;

  positional_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_item_count    (out_item_count),
    .out_last          (out_last)
  );

  ple_checker #(.CAPACITY(CAPACITY)) list_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_item_count    (out_item_count),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending           (pending),
    .list_len          (list_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [PosW-1:0] ins_pos();
    return PosW'($urandom_range(1, list_len + 1));
  endfunction

  function automatic logic [PosW-1:0] del_pos();
    if (list_len == 0) return PosW'(1);
    return PosW'($urandom_range(1, list_len));
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_item(input req_t req, input logic signed [ValW-1:0] val,
                           input logic [PosW-1:0] pos);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req != REQ_NONE) issued++;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic send_valid_op();
    req_t req;
    req = req_t'($urandom_range(0, 6));
    if (req == REQ_INS_POS) send_item(req, pick_value(), ins_pos());
    else if (req == REQ_DEL_POS) send_item(req, pick_value(), del_pos());
    else send_item(req, pick_value(), PosW'($urandom));
  endtask

  // receiver: random hold-off modes plus one long hold on request
  initial begin
    int stall_left;
    int stall_mode;
    int mode_left;
    out_stall  = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(10, 40);
          default: ;
        endcase
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int seq_kind;
    int n;
    bit hold_done;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = '0;
    in_value          = '0;
    in_position       = '0;
    gaps_on           = 1'b1;
    long_hold_pending = 1'b0;
    issued            = 0;
    hold_done         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list
    send_item(REQ_READ_ALL, pick_value(), '0);
    send_item(REQ_DEL_FRONT, pick_value(), '0);
    send_item(REQ_DEL_BACK, pick_value(), '0);
    send_item(REQ_DEL_POS, pick_value(), 7'd1);
    send_item(REQ_INS_POS, pick_value(), 7'd0);
    send_item(REQ_INS_POS, pick_value(), 7'd2);
    // value extremes, front, back and positional inserts, bad positions, a no-op and a read-out
    send_item(REQ_INS_POS, 32'sh7FFFFFFF, 7'd1);
    send_item(REQ_INS_FRONT, 32'sh80000000, 7'd127);
    send_item(REQ_INS_BACK, -32'sd1, 7'd0);
    send_item(REQ_INS_POS, 32'shAAAAAAAA, 7'd4);
    send_item(REQ_INS_POS, 32'sh55555555, 7'd2);
    send_item(REQ_DEL_POS, pick_value(), 7'd127);
    send_item(REQ_INS_POS, pick_value(), 7'd127);
    send_item(REQ_NONE, $urandom, 7'd127);
    send_item(REQ_READ_ALL, pick_value(), '0);
    // fill, then hit the full list, read it out and delete from it
    while (list_len < CAPACITY) send_item(REQ_INS_BACK, pick_value(), PosW'($urandom));
    send_item(REQ_INS_FRONT, pick_value(), '0);
    send_item(REQ_INS_POS, pick_value(), 7'd0);
    send_item(REQ_INS_BACK, pick_value(), 7'd1);
    send_item(REQ_READ_ALL, pick_value(), '0);
    send_item(REQ_DEL_POS, pick_value(), PosW'(list_len + 1));
    send_item(REQ_DEL_POS, pick_value(), PosW'(list_len));
    send_item(REQ_DEL_POS, pick_value(), 7'd1);
    drain();

    while (issued < NUM_ITEMS) begin
      seq_kind = $urandom_range(0, 99);
      gaps_on  = ($urandom_range(0, 3) != 0);
      n        = $urandom_range(1, 8);
      if (!hold_done && issued >= 60) begin
        // hold the result side off and keep offering items
        hold_done         = 1'b1;
        gaps_on           = 1'b0;
        long_hold_pending = 1'b1;
        repeat (6) begin
          send_item(REQ_INS_BACK, pick_value(), PosW'($urandom));
          send_item(REQ_READ_ALL, pick_value(), PosW'($urandom));
        end
        drain();
      end else if (seq_kind < 40) begin
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: send_item(REQ_INS_FRONT, pick_value(), PosW'($urandom));
            1: send_item(REQ_INS_BACK, pick_value(), PosW'($urandom));
            default: send_item(REQ_INS_POS, pick_value(), ins_pos());
          endcase
        end
        send_item(REQ_READ_ALL, pick_value(), PosW'($urandom));
      end else if (seq_kind < 70) begin
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: send_item(REQ_DEL_FRONT, pick_value(), PosW'($urandom));
            1: send_item(REQ_DEL_BACK, pick_value(), PosW'($urandom));
            default: send_item(REQ_DEL_POS, pick_value(), del_pos());
          endcase
        end
        send_item(REQ_READ_ALL, pick_value(), PosW'($urandom));
      end else if (seq_kind < 85) begin
        repeat (n) send_valid_op();
      end else begin
        repeat (n) send_item(req_t'($urandom_range(0, 7)), pick_value(), PosW'($urandom));
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
